// ===== rtl/sae_pkg.sv =====
package sae_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT,
		CMD_DELETE,
		CMD_SEARCH,
		CMD_READ
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_BAD_INDEX,
		ST_NOT_FOUND
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SEARCH
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] item_value;
		logic [5:0]         position;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] data_out;
		logic [5:0]         found_at;
		logic [6:0]         fill_count;
	} rsp_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic               ins_en;
		logic               del_en;
		logic               cmp_en;
		logic signed [31:0] key;
		logic [5:0]         pos;
	} bcast_t;

endpackage

// ===== rtl/sae_cell.sv =====
module sae_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 7
) (
	input  logic                clk,
	input  sae_pkg::bcast_t     bc,
	input  logic [CNT_W-1:0]    count,
	input  logic signed [31:0]  left_val,
	input  logic                left_gtv,
	input  logic signed [31:0]  right_val,
	output logic signed [31:0]  val,
	output logic                gtv,
	output logic                eq,
	output logic                lt,
	output logic signed [31:0]  sel_val,
	output logic                ins_here
);

	localparam logic [31:0] IDX = 32'(INDEX);

	logic signed [31:0] val_q;
	logic               eq_q;
	logic               lt_q;
	logic [31:0]        cnt32;
	logic [31:0]        pos32;
	logic               take_left;
	logic               take_key;
	logic               take_right;

	assign cnt32 = 32'(count);
	assign pos32 = 32'(bc.pos);

	// entry is live and larger than the key: it moves up on insert
	assign gtv = (val_q > bc.key) && (IDX < cnt32);

	assign take_left  = bc.ins_en && left_gtv;
	assign take_key   = bc.ins_en && !left_gtv && (IDX <= cnt32) && ((IDX == cnt32) || gtv);
	assign take_right = bc.del_en && (IDX >= pos32) && ((IDX + 32'd1) < cnt32);

	assign ins_here = take_key;
	assign sel_val  = (IDX == pos32) ? val_q : 32'sd0;
	assign val      = val_q;
	assign eq       = eq_q;
	assign lt       = lt_q;

	always_ff @(posedge clk) begin
		if (take_left) begin
			val_q <= left_val;
		end else if (take_key) begin
			val_q <= bc.key;
		end else if (take_right) begin
			val_q <= right_val;
		end
		if (bc.cmp_en) begin
			eq_q <= (val_q == bc.key);
			lt_q <= (bc.key < val_q);
		end
	end

endmodule

// ===== rtl/sorted_array_engine_unit.sv =====
// Sorted array engine: keeps up to CAPACITY signed 32-bit values in ascending
// order in a row of cells, one value per cell.
// Request channel (req_valid, req_stall, req): insert, delete at index,
// binary search for a key, or read at index. Response channel (rsp_valid,
// rsp_stall, rsp): one response per request with status, data, position
// and the fill count after the request.
// Insert, delete and read: after the request is taken, the execute state
// loads the response register once the output is free; no new request is
// taken until the engine is back in idle. All cells shift in parallel, at
// the edge that loads the response register.
// Search: the cells compare against the key in the execute state, then the
// search walks one probe per cycle; the probe loop loads the response
// register once it finds the key or runs out of range and the output is free.
// One request is in work at a time; req_stall is high while it is.
// A response that is stalled holds in its register; the engine finishes the
// next request only up to the point where it would overwrite it.
// Reset empties the store (fill count zero) and drops any pending response;
// cell contents are not cleared, entries at or above the fill count are
// never read.
module sorted_array_engine_unit #(
	parameter int CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sae_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sae_pkg::rsp_t rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 2;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	sae_pkg::state_t state_q, state_d;
	sae_pkg::req_t   req_q;
	sae_pkg::rsp_t   rsp_q, rsp_d;
	sae_pkg::bcast_t bc;
	logic            rsp_valid_q;
	logic            rsp_load;
	logic [CW-1:0]   count_q, count_d;
	logic signed [SW-1:0] lo_q, hi_q, lo_d, hi_d;
	logic signed [SW-1:0] mid_sum;
	logic [IW-1:0]   mid_idx;
	logic            out_free;
	logic            full;
	logic            bad_index;
	logic            srch_done;

	logic signed [31:0] cell_val [CAPACITY];
	logic signed [31:0] cell_sel [CAPACITY];
	logic [CAPACITY-1:0] cell_gtv;
	logic [CAPACITY-1:0] cell_eq;
	logic [CAPACITY-1:0] cell_lt;
	logic [CAPACITY-1:0] cell_ins;
	logic signed [31:0] rd_data;
	logic [IW-1:0]      ins_pos;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic signed [31:0] lv;
			logic               lg;
			logic signed [31:0] rv;
			if (g == 0) begin : g_first
				assign lv = 32'sd0;
				assign lg = 1'b0;
			end else begin : g_mid
				assign lv = cell_val[g-1];
				assign lg = cell_gtv[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign rv = 32'sd0;
			end else begin : g_inner
				assign rv = cell_val[g+1];
			end
			sae_cell #(
				.INDEX(g),
				.CNT_W(CW)
			) u_cell (
				.clk      (clk),
				.bc       (bc),
				.count    (count_q),
				.left_val (lv),
				.left_gtv (lg),
				.right_val(rv),
				.val      (cell_val[g]),
				.gtv      (cell_gtv[g]),
				.eq       (cell_eq[g]),
				.lt       (cell_lt[g]),
				.sel_val  (cell_sel[g]),
				.ins_here (cell_ins[g])
			);
		end
	endgenerate

	// gather read data and insert position from the row
	always_comb begin
		rd_data = 32'sd0;
		ins_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | cell_sel[i];
			if (cell_ins[i]) begin
				ins_pos = ins_pos | IW'(i);
			end
		end
	end

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign full      = (count_q == CAP_C);
	assign bad_index = (32'(req_q.position) >= 32'(count_q));
	assign mid_sum   = lo_q + hi_q;
	assign mid_idx   = IW'(mid_sum >>> 1);
	assign srch_done = (lo_q > hi_q) || cell_eq[mid_idx];

	assign req_stall = (state_q != sae_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sae_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = sae_pkg::S_EXEC;
				end
			end
			sae_pkg::S_EXEC: begin
				if (out_free) begin
					state_d = (req_q.cmd == sae_pkg::CMD_SEARCH) ? sae_pkg::S_SEARCH
					                                            : sae_pkg::S_IDLE;
				end
			end
			sae_pkg::S_SEARCH: begin
				if (srch_done && out_free) begin
					state_d = sae_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sae_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		bc.ins_en = 1'b0;
		bc.del_en = 1'b0;
		bc.cmp_en = 1'b0;
		bc.key    = req_q.item_value;
		bc.pos    = req_q.position;
		count_d   = count_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		rsp_load  = 1'b0;
		rsp_d.status     = sae_pkg::ST_OK;
		rsp_d.data_out   = 32'sd0;
		rsp_d.found_at   = 6'd0;
		rsp_d.fill_count = 7'(count_q);
		case (state_q)
			sae_pkg::S_EXEC: begin
				if (out_free) begin
					case (req_q.cmd)
						sae_pkg::CMD_INSERT: begin
							rsp_load = 1'b1;
							if (full) begin
								rsp_d.status = sae_pkg::ST_FULL;
							end else begin
								bc.ins_en        = 1'b1;
								count_d          = count_q + CW'(1);
								rsp_d.found_at   = 6'(ins_pos);
								rsp_d.fill_count = 7'(count_d);
							end
						end
						sae_pkg::CMD_DELETE: begin
							rsp_load = 1'b1;
							if (bad_index) begin
								rsp_d.status = sae_pkg::ST_BAD_INDEX;
							end else begin
								bc.del_en        = 1'b1;
								count_d          = count_q - CW'(1);
								rsp_d.data_out   = rd_data;
								rsp_d.fill_count = 7'(count_d);
							end
						end
						sae_pkg::CMD_SEARCH: begin
							bc.cmp_en = 1'b1;
							lo_d      = '0;
							hi_d      = SW'(count_q) - SW'(1);
						end
						default: begin
							rsp_load = 1'b1;
							if (bad_index) begin
								rsp_d.status = sae_pkg::ST_BAD_INDEX;
							end else begin
								rsp_d.data_out = rd_data;
							end
						end
					endcase
				end
			end
			sae_pkg::S_SEARCH: begin
				if (srch_done) begin
					rsp_load = out_free;
					if (lo_q > hi_q) begin
						rsp_d.status = sae_pkg::ST_NOT_FOUND;
					end else begin
						rsp_d.found_at = 6'(mid_idx);
					end
				end else if (cell_lt[mid_idx]) begin
					hi_d = (mid_sum >>> 1) - SW'(1);
				end else begin
					lo_d = (mid_sum >>> 1) + SW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sae_pkg::S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sae_pkg::S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		lo_q <= lo_d;
		hi_q <= hi_d;
	end

endmodule

// ===== verif/tb_sorted_array_engine_unit.sv =====
module tb_sorted_array_engine_unit;

	localparam int CAP       = 64;
	localparam int LONG_HOLD = 300;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	sae_pkg::req_t  req       = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	sae_pkg::rsp_t  rsp;

	sorted_array_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// requests waiting to go out, responses owed by the engine
	sae_pkg::req_t cmd_backlog[$];
	sae_pkg::rsp_t due_rsps[$];

	// shadow copy of the sorted store
	logic signed [31:0] shadow_store [CAP];
	int                 shadow_count = 0;

	// generator's view: fill count is exact, values are a rough pool
	int                 gen_count = 0;
	bit                 filling   = 1'b1;
	logic signed [31:0] seen_vals[$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int holds_asked = 0;
	int holds_served;
	int hold_left;

	int            errors       = 0;
	int            reqs_sent    = 0;
	int            rsps_checked = 0;
	int            n_full       = 0;
	int            n_bad_idx    = 0;
	int            n_hit        = 0;
	int            n_miss       = 0;
	int            peak_fill    = 0;
	sae_pkg::rsp_t want;
	sae_pkg::rsp_t pred;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic sae_pkg::rsp_t execute_on_shadow(sae_pkg::req_t r);
		sae_pkg::rsp_t      o;
		logic signed [31:0] val;
		int                 i, lo, hi, mid;
		o = '0;
		o.status = sae_pkg::ST_OK;
		val = $signed(r.item_value);
		case (r.cmd)
			sae_pkg::CMD_INSERT: begin
				if (shadow_count >= CAP) begin
					o.status = sae_pkg::ST_FULL;
				end else begin
					// land after any equal entries
					i = shadow_count;
					while (i > 0 && shadow_store[i - 1] > val) begin
						shadow_store[i] = shadow_store[i - 1];
						i--;
					end
					shadow_store[i] = val;
					shadow_count++;
					o.found_at = i[5:0];
				end
			end
			sae_pkg::CMD_DELETE: begin
				if (r.position >= shadow_count) begin
					o.status = sae_pkg::ST_BAD_INDEX;
				end else begin
					o.data_out = shadow_store[r.position];
					for (i = r.position; i + 1 < shadow_count; i++)
						shadow_store[i] = shadow_store[i + 1];
					shadow_count--;
				end
			end
			sae_pkg::CMD_SEARCH: begin
				lo = 0;
				hi = shadow_count - 1;
				o.status = sae_pkg::ST_NOT_FOUND;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (shadow_store[mid] == val) begin
						o.status = sae_pkg::ST_OK;
						o.found_at = mid[5:0];
						break;
					end else if (val < shadow_store[mid]) begin
						hi = mid - 1;
					end else begin
						lo = mid + 1;
					end
				end
			end
			default: begin
				if (r.position >= shadow_count)
					o.status = sae_pkg::ST_BAD_INDEX;
				else
					o.data_out = shadow_store[r.position];
			end
		endcase
		o.fill_count = shadow_count[6:0];
		return o;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		errors++;
	endtask

	// driver: holds a stalled request steady, picks the next one once taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				pred = execute_on_shadow(req);
				due_rsps = {due_rsps, pred};
				if (req.cmd == sae_pkg::CMD_SEARCH && pred.status == sae_pkg::ST_OK)
					n_hit++;
				reqs_sent++;
			end
			if (!req_valid || !req_stall) begin
				if (cmd_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					req_valid <= 1'b1;
					req <= cmd_backlog.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response side back-pressure, with an occasional long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			holds_served <= 0;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			rsp_stall <= 1'b1;
			hold_left <= LONG_HOLD - 1;
			holds_served <= holds_served + 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_rsps.size() == 0) begin
				flag_mismatch("response with no request outstanding");
			end else begin
				want = due_rsps.pop_front();
				if (rsp.status !== want.status)
					flag_mismatch($sformatf("rsp %0d status %0d want %0d",
						rsps_checked, rsp.status, want.status));
				if (rsp.data_out !== want.data_out)
					flag_mismatch($sformatf("rsp %0d data_out %0d want %0d",
						rsps_checked, rsp.data_out, want.data_out));
				if (rsp.found_at !== want.found_at)
					flag_mismatch($sformatf("rsp %0d found_at %0d want %0d",
						rsps_checked, rsp.found_at, want.found_at));
				if (rsp.fill_count !== want.fill_count)
					flag_mismatch($sformatf("rsp %0d fill_count %0d want %0d",
						rsps_checked, rsp.fill_count, want.fill_count));
				case (want.status)
					sae_pkg::ST_FULL:      n_full++;
					sae_pkg::ST_BAD_INDEX: n_bad_idx++;
					sae_pkg::ST_NOT_FOUND: n_miss++;
					default:               ;
				endcase
				if (want.fill_count > peak_fill)
					peak_fill = want.fill_count;
				rsps_checked++;
			end
		end
	end

	function automatic void push_cmd(input sae_pkg::cmd_t c, input logic signed [31:0] v,
			input logic [5:0] p);
		sae_pkg::req_t r;
		r.cmd = c;
		r.item_value = v;
		r.position = p;
		cmd_backlog = {cmd_backlog, r};
		case (c)
			sae_pkg::CMD_INSERT: begin
				if (gen_count < CAP) begin
					gen_count++;
					seen_vals = {seen_vals, v};
					if (seen_vals.size() > CAP)
						void'(seen_vals.pop_front());
				end
			end
			sae_pkg::CMD_DELETE: begin
				if (p < gen_count)
					gen_count--;
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 25 && seen_vals.size() > 0)
			return seen_vals[$urandom_range(seen_vals.size() - 1)];
		if (roll < 40) begin
			case ($urandom_range(4))
				0:       return 32'sh8000_0000;
				1:       return 32'sh7fff_ffff;
				2:       return 32'sh0;
				3:       return -32'sd1;
				default: return 32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	// sweeps the store between empty and full; searches mostly use values put in
	task automatic queue_random(input int n);
		int                 roll, ins_w, del_w;
		logic [5:0]         p;
		logic signed [31:0] key;
		repeat (n) begin
			if (gen_count == 0)
				filling = 1'b1;
			else if (gen_count == CAP && $urandom_range(3) == 0)
				filling = 1'b0;
			ins_w = filling ? 60 : 12;
			del_w = filling ? 12 : 60;
			if (gen_count > 0 && $urandom_range(99) < 85)
				p = 6'($urandom_range(gen_count - 1));
			else
				p = 6'($urandom_range(63));
			if (seen_vals.size() > 0 && $urandom_range(99) < 55)
				key = seen_vals[$urandom_range(seen_vals.size() - 1)];
			else
				key = pick_value();
			roll = $urandom_range(99);
			if (roll < ins_w)
				push_cmd(sae_pkg::CMD_INSERT, pick_value(), p);
			else if (roll < ins_w + del_w)
				push_cmd(sae_pkg::CMD_DELETE, pick_value(), p);
			else if (roll < ins_w + del_w + 16)
				push_cmd(sae_pkg::CMD_SEARCH, key, p);
			else
				push_cmd(sae_pkg::CMD_READ, pick_value(), p);
		end
	endtask

	task automatic wait_all_answered();
		while (cmd_backlog.size() != 0 || req_valid || due_rsps.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 6;
		rx_idle_pct = 77;
		// empty store first
		push_cmd(sae_pkg::CMD_SEARCH, 32'sd0, 6'd0);
		push_cmd(sae_pkg::CMD_READ, 32'sd0, 6'd0);
		push_cmd(sae_pkg::CMD_DELETE, 32'sd0, 6'd0);
		push_cmd(sae_pkg::CMD_INSERT, 32'sh7fff_ffff, 6'd0);
		push_cmd(sae_pkg::CMD_INSERT, 32'sh8000_0000, 6'd63);
		push_cmd(sae_pkg::CMD_INSERT, 32'sd0, 6'd0);
		push_cmd(sae_pkg::CMD_INSERT, 32'sd0, 6'd0);
		push_cmd(sae_pkg::CMD_INSERT, 32'sd0, 6'd0);
		push_cmd(sae_pkg::CMD_INSERT, -32'sd1, 6'd0);
		push_cmd(sae_pkg::CMD_INSERT, 32'sd1, 6'd0);
		// duplicates: the probe lands on some middle zero
		push_cmd(sae_pkg::CMD_SEARCH, 32'sd0, 6'd0);
		push_cmd(sae_pkg::CMD_SEARCH, 32'sh8000_0000, 6'd0);
		push_cmd(sae_pkg::CMD_SEARCH, 32'sh7fff_ffff, 6'd0);
		push_cmd(sae_pkg::CMD_SEARCH, 32'sd2, 6'd0);
		push_cmd(sae_pkg::CMD_SEARCH, -32'sd2, 6'd0);
		push_cmd(sae_pkg::CMD_READ, 32'sd0, 6'd0);
		push_cmd(sae_pkg::CMD_READ, 32'sd0, 6'd6);
		push_cmd(sae_pkg::CMD_READ, 32'sd0, 6'd7);
		push_cmd(sae_pkg::CMD_READ, -32'sd1, 6'd63);
		push_cmd(sae_pkg::CMD_DELETE, 32'sd0, 6'd6);
		push_cmd(sae_pkg::CMD_DELETE, 32'sd0, 6'd0);
		push_cmd(sae_pkg::CMD_DELETE, 32'sd0, 6'd63);
		push_cmd(sae_pkg::CMD_DELETE, 32'sd0, 6'd2);
		wait_all_answered();

		// long response hold while requests keep coming; fills the store past full
		holds_asked++;
		repeat (CAP - gen_count + 2)
			push_cmd(sae_pkg::CMD_INSERT, pick_value(), 6'($urandom_range(63)));
		wait_all_answered();

		queue_random(310);
		wait_all_answered();

		tx_idle_pct = 77;
		rx_idle_pct = 6;
		queue_random(310);
		wait_all_answered();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_random(320);
		wait_all_answered();
		repeat (20) @(negedge clk);

		$display("Covered %0d requests, %0d responses checked, store peaked at %0d entries.",
			reqs_sent, rsps_checked, peak_fill);
		$display("Refused as full %0d, bad index %0d, search hits %0d, misses %0d.",
			n_full, n_bad_idx, n_hit, n_miss);
		if (errors == 0)
			$display("sorted_array_engine_unit verification clean");
		else
			$display("sorted_array_engine_unit verification failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("sorted_array_engine_unit verification failed");
		$finish;
	end

endmodule

// ===== sorted_array_engine_unit.f =====
rtl/sae_pkg.sv
rtl/sae_cell.sv
rtl/sorted_array_engine_unit.sv
verif/tb_sorted_array_engine_unit.sv
